/* rtl/core/hsv_to_rgb_rainbow_assert.svh */
// assertion macros shared by the hsv to rgb pipeline
// each macro expects clk and rst_n in scope
`ifndef HSV_TO_RGB_RAINBOW_ASSERT_SVH
`define HSV_TO_RGB_RAINBOW_ASSERT_SVH

// consequent checked in the same cycle
`define HSVR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_rainbow: assertion failed");

// consequent checked in the next cycle
`define HSVR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_rainbow: assertion failed");

`endif

/* rtl/core/hsvr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsvr_pkg;

    localparam logic [7:0] FULL_LEVEL   = 8'd255;
    localparam logic [7:0] ANCHOR_LOW   = 8'd85;
    localparam logic [7:0] ANCHOR_HIGH  = 8'd171;
    localparam logic [7:0] THIRD_SCALE  = 8'd85;   // 256 / 3
    localparam logic [7:0] TWOTH_SCALE  = 8'd170;  // 256 * 2 / 3

    // hue sections, eight of 32 steps each
    typedef enum logic [2:0] {
        SEC_RED    = 3'd0,
        SEC_ORANGE = 3'd1,
        SEC_YELLOW = 3'd2,
        SEC_GREEN  = 3'd3,
        SEC_AQUA   = 3'd4,
        SEC_BLUE   = 3'd5,
        SEC_PURPLE = 3'd6,
        SEC_PINK   = 3'd7
    } hue_sec_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // after hue mapping
    typedef struct packed {
        rgb_t       rgb;
        logic [7:0] sat;
        logic [7:0] flr;
        logic [7:0] v2;
        logic       val_full;
    } hue_word_t;

    // after saturation
    typedef struct packed {
        rgb_t       rgb;
        logic [7:0] v2;
        logic       val_full;
    } sat_word_t;

    function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] s);
        logic [15:0] p;
        p = x * s;
        return p[15:8];
    endfunction

    // nonzero channels get scaled plus one, zero stays zero
    function automatic logic [7:0] scale8_nz(input logic [7:0] x, input logic [7:0] s);
        logic [7:0] q;
        q = scale8(x, s) + 8'd1;
        return (x == 8'd0) ? 8'd0 : q;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hsvr_hue_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module hsvr_hue_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire hsvr_pkg::hsv_t    in_word,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      hsvr_pkg::hue_word_t out_word
);

    logic                valid_reg;
    hsvr_pkg::hue_word_t word_reg;
    hsvr_pkg::hue_word_t word_next;
    logic [7:0]          off8;
    logic [7:0]          third;
    logic [7:0]          twoth;
    logic [7:0]          dsat;
    logic                in_fire;

    assign off8  = {in_word.hue[4:0], 3'b000};
    assign third = hsvr_pkg::scale8(off8, hsvr_pkg::THIRD_SCALE);
    assign twoth = hsvr_pkg::scale8(off8, hsvr_pkg::TWOTH_SCALE);
    assign dsat  = hsvr_pkg::FULL_LEVEL - in_word.sat;

    always_comb
    begin
        word_next.rgb = '0;
        case (hsvr_pkg::hue_sec_t'(in_word.hue[7:5]))
            hsvr_pkg::SEC_RED:
            begin
                word_next.rgb.r = hsvr_pkg::FULL_LEVEL - third;
                word_next.rgb.g = third;
            end
            hsvr_pkg::SEC_ORANGE:
            begin
                word_next.rgb.r = hsvr_pkg::ANCHOR_HIGH;
                word_next.rgb.g = hsvr_pkg::ANCHOR_LOW + third;
            end
            hsvr_pkg::SEC_YELLOW:
            begin
                word_next.rgb.r = hsvr_pkg::ANCHOR_HIGH - twoth;
                word_next.rgb.g = hsvr_pkg::ANCHOR_HIGH + third;
            end
            hsvr_pkg::SEC_GREEN:
            begin
                word_next.rgb.g = hsvr_pkg::FULL_LEVEL - third;
                word_next.rgb.b = third;
            end
            hsvr_pkg::SEC_AQUA:
            begin
                word_next.rgb.g = hsvr_pkg::ANCHOR_HIGH - twoth;
                word_next.rgb.b = hsvr_pkg::ANCHOR_LOW + twoth;
            end
            hsvr_pkg::SEC_BLUE:
            begin
                word_next.rgb.r = third;
                word_next.rgb.b = hsvr_pkg::FULL_LEVEL - third;
            end
            hsvr_pkg::SEC_PURPLE:
            begin
                word_next.rgb.r = hsvr_pkg::ANCHOR_LOW + third;
                word_next.rgb.b = hsvr_pkg::ANCHOR_HIGH - third;
            end
            hsvr_pkg::SEC_PINK:
            begin
                word_next.rgb.r = hsvr_pkg::ANCHOR_HIGH + third;
                word_next.rgb.b = hsvr_pkg::ANCHOR_LOW - third;
            end
            default:
            begin
                word_next.rgb = '0;
            end
        endcase
        word_next.sat      = in_word.sat;
        word_next.flr      = hsvr_pkg::scale8(dsat, dsat);
        // squared brightness with video rounding
        word_next.v2       = hsvr_pkg::scale8(in_word.val, in_word.val)
                             + {7'd0, (in_word.val != 8'd0)};
        word_next.val_full = (in_word.val == hsvr_pkg::FULL_LEVEL);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hsvr_sat_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_rainbow_assert.svh"

module hsvr_sat_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire hsvr_pkg::hue_word_t in_word,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      hsvr_pkg::sat_word_t out_word
);

    logic                valid_reg;
    hsvr_pkg::sat_word_t word_reg;
    hsvr_pkg::sat_word_t word_next;
    logic                in_fire;

    always_comb
    begin
        word_next.v2       = in_word.v2;
        word_next.val_full = in_word.val_full;
        if (in_word.sat == hsvr_pkg::FULL_LEVEL)
        begin
            word_next.rgb = in_word.rgb;
        end
        else if (in_word.sat == 8'd0)
        begin
            // no saturation gives white
            word_next.rgb.r = hsvr_pkg::FULL_LEVEL;
            word_next.rgb.g = hsvr_pkg::FULL_LEVEL;
            word_next.rgb.b = hsvr_pkg::FULL_LEVEL;
        end
        else
        begin
            word_next.rgb.r = hsvr_pkg::scale8_nz(in_word.rgb.r, in_word.sat) + in_word.flr;
            word_next.rgb.g = hsvr_pkg::scale8_nz(in_word.rgb.g, in_word.sat) + in_word.flr;
            word_next.rgb.b = hsvr_pkg::scale8_nz(in_word.rgb.b, in_word.sat) + in_word.flr;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= word_next;
        end
    end

    `HSVR_ASSERT_NEXT(a_sat_zero_white, in_fire && (in_word.sat == 8'd0), valid_reg && (word_reg.rgb == {3{hsvr_pkg::FULL_LEVEL}}))
    `HSVR_ASSERT_NEXT(a_sat_full_pass, in_fire && (in_word.sat == hsvr_pkg::FULL_LEVEL), word_reg.rgb == $past(in_word.rgb))

endmodule

`default_nettype wire

/* rtl/core/hsvr_val_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_rainbow_assert.svh"

module hsvr_val_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire hsvr_pkg::sat_word_t in_word,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      hsvr_pkg::rgb_t      out_word
);

    logic           valid_reg;
    hsvr_pkg::rgb_t word_reg;
    hsvr_pkg::rgb_t word_next;
    logic           in_fire;

    always_comb
    begin
        if (in_word.val_full)
        begin
            word_next = in_word.rgb;
        end
        else if (in_word.v2 == 8'd0)
        begin
            word_next = '0;
        end
        else
        begin
            word_next.r = hsvr_pkg::scale8_nz(in_word.rgb.r, in_word.v2);
            word_next.g = hsvr_pkg::scale8_nz(in_word.rgb.g, in_word.v2);
            word_next.b = hsvr_pkg::scale8_nz(in_word.rgb.b, in_word.v2);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= word_next;
        end
    end

    `HSVR_ASSERT_NEXT(a_val_dark_black, in_fire && !in_word.val_full && (in_word.v2 == 8'd0), valid_reg && (word_reg == '0))

endmodule

`default_nettype wire

/* rtl/core/hsv_to_rgb_rainbow.sv */
`timescale 1ns / 1ps
`default_nettype none

// hsv to rgb converter with the rainbow hue map. takes one pixel word per clock
// when the output side is ready and returns one rgb word per pixel, in order.
// the rate of one word per cycle is held by three register stages, each built
// around one bank of 8x8 multipliers: hue mapping (plus the desaturation floor
// and brightness square), saturation scaling, and brightness scaling. each stage
// carries its own valid bit and only stalls when the stage after it is full, so
// bubbles close up and no word is lost or repeated. all channel sums wrap modulo
// 256. saturation 0 gives white, brightness 0 gives black. there is no state
// between pixels and no configuration.

`include "hsv_to_rgb_rainbow_assert.svh"

module hsv_to_rgb_rainbow (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    // output words
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata    // red [7:0], green [15:8], blue [23:16]
);

    hsvr_pkg::hsv_t      hsv_in;
    hsvr_pkg::hue_word_t hue_word;
    hsvr_pkg::sat_word_t sat_word;
    hsvr_pkg::rgb_t      rgb_word;
    logic                hue_valid;
    logic                hue_ready;
    logic                sat_valid;
    logic                sat_ready;

    // unpack the input word, hue in the low byte
    assign hsv_in.hue = s_axis_tdata[7:0];
    assign hsv_in.sat = s_axis_tdata[15:8];
    assign hsv_in.val = s_axis_tdata[23:16];

    // stage 1: hue section map, desaturation floor, squared brightness
    hsvr_hue_stage u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (hsv_in),
        .out_valid (hue_valid),
        .out_ready (hue_ready),
        .out_word  (hue_word)
    );

    // stage 2: saturation
    hsvr_sat_stage u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .in_word   (hue_word),
        .out_valid (sat_valid),
        .out_ready (sat_ready),
        .out_word  (sat_word)
    );

    // stage 3: brightness, doubles as the output register
    hsvr_val_stage u_val (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_word   (sat_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (rgb_word)
    );

    // pack the output word, red in the low byte
    assign m_axis_tdata = {rgb_word.b, rgb_word.g, rgb_word.r};

    // input side only backs up when every stage holds a word and the sink stalls
    `HSVR_ASSERT_NOW(a_full_when_blocked, !s_axis_tready, m_axis_tvalid && !m_axis_tready && hue_valid && sat_valid)

endmodule

`default_nettype wire

/* sim/hsv_to_rgb_rainbow_tb.sv */
`timescale 1ns / 1ps

module hsv_to_rgb_rainbow_tb;

    // run length guard and shaping constants
    localparam int CYCLE_LIMIT   = 100000;  // far above the slowest correct run
    localparam int LONG_STALL    = 200;     // receiver hold-off for the pressure test
    localparam int DRAIN_CYCLES  = 8;       // pipeline is three deep, leave some slack
    localparam int MAX_REPORTS   = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // hue [7:0], saturation [15:8], brightness [23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // red [7:0], green [15:8], blue [23:16]

    // predicted rgb words, oldest first
    hsvr_pkg::rgb_t pending_rgb[$];
    int             mismatch_count;
    int             cycle_count;

    // idling controls shared with the receiver
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          stall_ask;

    hsv_to_rgb_rainbow u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // color math
    // ------------------------------------------------------------------

    // upper byte of an 8x8 product, i.e. a fractional multiply by s/256
    function automatic logic [7:0] frac_mul(input logic [7:0] a, input logic [7:0] s);
        logic [15:0] prod;
        prod = a * s;
        return prod[15:8];
    endfunction

    // scaling that keeps a lit channel lit: zero stays zero, else scaled plus one
    function automatic logic [7:0] frac_mul_lit(input logic [7:0] a, input logic [7:0] s);
        logic [7:0] q;
        q = frac_mul(a, s) + 8'd1;
        return (a == 8'd0) ? 8'd0 : q;
    endfunction

    // rainbow hue map followed by saturation and brightness
    function automatic hsvr_pkg::rgb_t rainbow_rgb(input logic [7:0] hue,
                                                   input logic [7:0] sat,
                                                   input logic [7:0] val);
        hsvr_pkg::rgb_t c;
        logic [7:0]     off8;
        logic [7:0]     third;
        logic [7:0]     twoth;
        logic [7:0]     desat;
        logic [7:0]     floor_lvl;
        logic [7:0]     val_sq;
        off8  = {hue[4:0], 3'b000};
        third = frac_mul(off8, hsvr_pkg::THIRD_SCALE);
        twoth = frac_mul(off8, hsvr_pkg::TWOTH_SCALE);
        // each section ramps between the anchors 0, 85, 171 and 255
        case (hsvr_pkg::hue_sec_t'(hue[7:5]))
            hsvr_pkg::SEC_RED:
                c = '{hsvr_pkg::FULL_LEVEL - third, third, 8'd0};
            hsvr_pkg::SEC_ORANGE:
                c = '{hsvr_pkg::ANCHOR_HIGH, hsvr_pkg::ANCHOR_LOW + third, 8'd0};
            hsvr_pkg::SEC_YELLOW:
                c = '{hsvr_pkg::ANCHOR_HIGH - twoth, hsvr_pkg::ANCHOR_HIGH + third, 8'd0};
            hsvr_pkg::SEC_GREEN:
                c = '{8'd0, hsvr_pkg::FULL_LEVEL - third, third};
            hsvr_pkg::SEC_AQUA:
                c = '{8'd0, hsvr_pkg::ANCHOR_HIGH - twoth, hsvr_pkg::ANCHOR_LOW + twoth};
            hsvr_pkg::SEC_BLUE:
                c = '{third, 8'd0, hsvr_pkg::FULL_LEVEL - third};
            hsvr_pkg::SEC_PURPLE:
                c = '{hsvr_pkg::ANCHOR_LOW + third, 8'd0, hsvr_pkg::ANCHOR_HIGH - third};
            default:
                c = '{hsvr_pkg::ANCHOR_HIGH + third, 8'd0, hsvr_pkg::ANCHOR_LOW - third};
        endcase
        // zero saturation is white, partial adds a squared desaturation floor
        if (sat == 8'd0)
        begin
            c = '{hsvr_pkg::FULL_LEVEL, hsvr_pkg::FULL_LEVEL, hsvr_pkg::FULL_LEVEL};
        end
        else if (sat != hsvr_pkg::FULL_LEVEL)
        begin
            desat     = hsvr_pkg::FULL_LEVEL - sat;
            floor_lvl = frac_mul(desat, desat);
            c.r = frac_mul_lit(c.r, sat) + floor_lvl;
            c.g = frac_mul_lit(c.g, sat) + floor_lvl;
            c.b = frac_mul_lit(c.b, sat) + floor_lvl;
        end
        // partial brightness is squared with video rounding first
        if (val != hsvr_pkg::FULL_LEVEL)
        begin
            val_sq = frac_mul(val, val) + ((val != 8'd0) ? 8'd1 : 8'd0);
            if (val_sq == 8'd0)
            begin
                c = '{8'd0, 8'd0, 8'd0};
            end
            else
            begin
                c.r = frac_mul_lit(c.r, val_sq);
                c.g = frac_mul_lit(c.g, val_sq);
                c.b = frac_mul_lit(c.b, val_sq);
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // monitor: predict on input handshake, check on output handshake
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        hsvr_pkg::rgb_t want;
        hsvr_pkg::rgb_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_rgb.push_back(rainbow_rgb(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                  s_axis_tdata[23:16]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
                if (pending_rgb.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected rgb word r=%0d g=%0d b=%0d", got.r, got.g, got.b);
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    if (got.r !== want.r || got.g !== want.g || got.b !== want.b)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"rgb mismatch: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     want.r, want.g, want.b, got.r, got.g, got.b);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random ready bursts and on request one long hold-off
    // ------------------------------------------------------------------

    initial
    begin
        int idle_left;
        int stall_seen;
        idle_left  = 0;
        stall_seen = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_ask != stall_seen)
            begin
                // long hold-off so the pipeline fills and input ready drops
                stall_seen = stall_ask;
                idle_left  = LONG_STALL;
            end
            else if (idle_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                idle_left = $urandom_range(1, 4);
            end
            if (idle_left > 0)
            begin
                m_axis_tready <= 1'b0;
                idle_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one pixel word and hold it until taken, called right after a rising edge
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, sat, hue};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // levels lean toward the boundary values now and then
    function automatic logic [7:0] pick_level();
        logic [7:0] edge_lvl[4];
        edge_lvl = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return edge_lvl[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // section boundaries plus the white, black and partial corner cases
    task automatic test_directed();
        logic [7:0] sat_pick[8];
        logic [7:0] val_pick[8];
        sat_pick = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd255, 8'd200, 8'd1};
        val_pick = '{8'd255, 8'd255, 8'd0, 8'd1, 8'd254, 8'd15, 8'd128, 8'd255};
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            // first step of each section, fully saturated and full brightness
            send_pixel(8'(k * 32), hsvr_pkg::FULL_LEVEL, hsvr_pkg::FULL_LEVEL);
            // last step of each section with a saturation / brightness corner
            send_pixel(8'(k * 32 + 31), sat_pick[k], val_pick[k]);
        end
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd100, 8'd1, 8'd1);
        send_pixel(8'd200, 8'd254, 8'd254);
    endtask

    // random pixels with idling on both sides
    task automatic test_random(input int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure(input int count);
        tx_idle_on = 1'b0;
        stall_ask  = stall_ask + 1;
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
    endtask

    // back-to-back streaming with no idling anywhere
    task automatic test_streaming(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        stall_ask      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(600);
        test_backpressure(50);
        test_streaming(300);
        s_axis_tvalid <= 1'b0;

        // let every predicted word come back, then a few more cycles
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_rgb.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
